### rtl/core/dispi9_pkg.sv
package dispi9_pkg;

	localparam int unsigned COUNT_WIDTH_DEFAULT = 16;
	localparam int unsigned CFG_WIDTH = 16;
	localparam int unsigned CFG_INDEX_WIDTH = 3;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PHASE_TICKS    = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SLEEP_IN_WAIT  = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SLEEP_OUT_WAIT = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_COLMOD_ARG     = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAMSET_ARG     = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MADCTL_ARG     = 3'd5;

	localparam logic [15:0] PHASE_TICKS_RESET    = 16'd1000;
	localparam logic [15:0] SLEEP_IN_WAIT_RESET  = 16'd250;
	localparam logic [15:0] SLEEP_OUT_WAIT_RESET = 16'd150;
	localparam logic [7:0]  COLMOD_ARG_RESET     = 8'h70;
	localparam logic [7:0]  GAMSET_ARG_RESET     = 8'h00;
	localparam logic [7:0]  MADCTL_ARG_RESET     = 8'h00;

	localparam logic [7:0] OP_SLPIN   = 8'h10;
	localparam logic [7:0] OP_SWRESET = 8'h01;
	localparam logic [7:0] OP_NOP     = 8'h00;
	localparam logic [7:0] OP_COLMOD  = 8'h3A;
	localparam logic [7:0] OP_GAMSET  = 8'h26;
	localparam logic [7:0] OP_MADCTL  = 8'h36;
	localparam logic [7:0] OP_SLPOUT  = 8'h11;
	localparam logic [7:0] OP_DISPON  = 8'h29;
	localparam logic [7:0] OP_INVOFF  = 8'h20;

	localparam logic [1:0] MODE_ON      = 2'd0;
	localparam logic [1:0] MODE_OFF     = 2'd1;
	localparam logic [1:0] MODE_REFRESH = 2'd2;
	localparam logic [1:0] MODE_UNKNOWN = 2'd3;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
	localparam logic [1:0] STATUS_IGNORED = 2'd2;

	localparam logic [6:0] LAST_SLOT_SHORT = 7'd48;
	localparam logic [6:0] LAST_SLOT_LONG  = 7'd93;

	typedef enum logic [1:0] {
		KIND_CMD      = 2'd0,
		KIND_WAIT_IN  = 2'd1,
		KIND_WAIT_OUT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ARG_NONE   = 2'd0,
		ARG_COLMOD = 2'd1,
		ARG_GAMSET = 2'd2,
		ARG_MADCTL = 2'd3
	} argsel_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] op;
		argsel_t    argsel;
	} entry_t;

	typedef struct packed {
		logic       chip_select;
		logic       serial_clock;
		logic       serial_data;
		logic       busy_res;
		logic       finished;
		logic [1:0] status;
	} res_t;

	function automatic entry_t script_entry(input logic [1:0] m, input logic [3:0] s);
		entry_t e;
		e = '{kind: KIND_CMD, op: OP_NOP, argsel: ARG_NONE};
		case (s)
			4'd0: e.op = OP_SLPIN;
			4'd1: e.kind = KIND_WAIT_IN;
			4'd2: e.op = OP_SWRESET;
			4'd3: e.op = OP_NOP;
			4'd4: begin
				if (m == MODE_OFF) begin
					e.op = OP_SLPIN;
				end else begin
					e.op = OP_COLMOD;
					e.argsel = ARG_COLMOD;
				end
			end
			4'd5: begin
				if (m == MODE_OFF) begin
					e.kind = KIND_WAIT_IN;
				end else begin
					e.op = OP_GAMSET;
					e.argsel = ARG_GAMSET;
				end
			end
			4'd6: begin
				e.op = OP_MADCTL;
				e.argsel = ARG_MADCTL;
			end
			4'd7: e.op = (m == MODE_ON) ? OP_SLPOUT : OP_INVOFF;
			4'd8: begin
				if (m == MODE_ON) begin
					e.kind = KIND_WAIT_OUT;
				end else begin
					e.op = OP_DISPON;
				end
			end
			4'd9: e.op = (m == MODE_ON) ? OP_DISPON : OP_SLPOUT;
			default: e.op = OP_NOP;
		endcase
		return e;
	endfunction

	function automatic logic [3:0] script_len(input logic [1:0] m);
		logic [3:0] len;
		case (m)
			MODE_ON:      len = 4'd10;
			MODE_OFF:     len = 4'd6;
			MODE_REFRESH: len = 4'd10;
			default:      len = 4'd4;
		endcase
		return len;
	endfunction

endpackage

### rtl/core/dispi9_core.sv
module dispi9_core import dispi9_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0]       cfg_wdata,
	input  logic                       take,
	input  logic                       action,
	input  logic [1:0]                 mode,
	output res_t                       res
);

	logic [15:0] phase_ticks_q;
	logic [15:0] sleep_in_wait_q;
	logic [15:0] sleep_out_wait_q;
	logic [7:0]  colmod_arg_q;
	logic [7:0]  gamset_arg_q;
	logic [7:0]  madctl_arg_q;

	logic [3:0]             step_q, step_d;
	logic [6:0]             slot_q, slot_d;
	logic [2:0]             sub_q, sub_d;
	logic [4:0]             bit_q, bit_d;
	logic [COUNT_WIDTH-1:0] tick_q, tick_d;
	logic [COUNT_WIDTH-1:0] wait_q, wait_d;
	logic [1:0]             mode_q, mode_d;
	logic                   running_q, running_d;
	logic                   sel_q, sel_d;
	logic                   clk_q, clk_d;
	logic                   dat_q, dat_d;

	entry_t                 ent;
	entry_t                 ent_p1;
	logic [3:0]             len;
	logic [3:0]             step_p1;
	logic [3:0]             step_adv;
	logic                   adv_end;
	logic [COUNT_WIDTH-1:0] pt;
	logic [COUNT_WIDTH-1:0] wlen;
	logic [COUNT_WIDTH-1:0] wlen_p1;
	logic [COUNT_WIDTH-1:0] tick_inc;
	logic [COUNT_WIDTH-1:0] wait_inc;
	logic [6:0]             last_slot;
	logic [6:0]             slot_inc;
	logic [8:0]             word;
	logic [3:0]             bit_k;
	logic                   bit_val;
	logic                   do_adv;
	logic                   fin;
	logic [1:0]             status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RESET;
			sleep_in_wait_q <= SLEEP_IN_WAIT_RESET;
			sleep_out_wait_q <= SLEEP_OUT_WAIT_RESET;
			colmod_arg_q <= COLMOD_ARG_RESET;
			gamset_arg_q <= GAMSET_ARG_RESET;
			madctl_arg_q <= MADCTL_ARG_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_PHASE_TICKS:    phase_ticks_q <= cfg_wdata;
				REG_SLEEP_IN_WAIT:  sleep_in_wait_q <= cfg_wdata;
				REG_SLEEP_OUT_WAIT: sleep_out_wait_q <= cfg_wdata;
				REG_COLMOD_ARG:     colmod_arg_q <= cfg_wdata[7:0];
				REG_GAMSET_ARG:     gamset_arg_q <= cfg_wdata[7:0];
				REG_MADCTL_ARG:     madctl_arg_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign pt = COUNT_WIDTH'(phase_ticks_q);
	assign len = script_len(mode_q);
	assign ent = script_entry(mode_q, step_q);
	assign step_p1 = step_q + 4'd1;
	assign ent_p1 = script_entry(mode_q, step_p1);
	assign wlen = (ent.kind == KIND_WAIT_IN) ? COUNT_WIDTH'(sleep_in_wait_q)
		: COUNT_WIDTH'(sleep_out_wait_q);
	assign wlen_p1 = (ent_p1.kind == KIND_WAIT_IN) ? COUNT_WIDTH'(sleep_in_wait_q)
		: COUNT_WIDTH'(sleep_out_wait_q);

	// A wait of zero phases is skipped; a wait is always followed by a command or the end.
	assign step_adv = (step_p1 < len && ent_p1.kind != KIND_CMD && wlen_p1 == '0)
		? step_q + 4'd2 : step_p1;
	assign adv_end = step_adv >= len;

	assign tick_inc = tick_q + COUNT_WIDTH'(1);
	assign wait_inc = wait_q + COUNT_WIDTH'(1);
	assign slot_inc = slot_q + 7'd1;
	assign last_slot = (ent.argsel != ARG_NONE) ? LAST_SLOT_LONG : LAST_SLOT_SHORT;

	always_comb begin
		case (ent.argsel)
			ARG_COLMOD: word = {1'b1, colmod_arg_q};
			ARG_GAMSET: word = {1'b1, gamset_arg_q};
			ARG_MADCTL: word = {1'b1, madctl_arg_q};
			default:    word = {1'b1, 8'h00};
		endcase
		if (bit_q < 5'd9) begin
			word = {1'b0, ent.op};
			bit_k = bit_q[3:0];
		end else begin
			bit_k = 4'(bit_q - 5'd9);
		end
		bit_val = (bit_k <= 4'd8) ? word[4'd8 - bit_k] : 1'b0;
	end

	always_comb begin
		step_d = step_q;
		slot_d = slot_q;
		sub_d = sub_q;
		bit_d = bit_q;
		tick_d = tick_q;
		wait_d = wait_q;
		mode_d = mode_q;
		running_d = running_q;
		sel_d = sel_q;
		clk_d = clk_q;
		dat_d = dat_q;
		do_adv = 1'b0;
		fin = 1'b0;
		status = STATUS_OK;
		if (action) begin
			if (running_q) begin
				status = STATUS_IGNORED;
			end else begin
				mode_d = mode;
				running_d = 1'b1;
				step_d = '0;
				slot_d = '0;
				sub_d = '0;
				bit_d = '0;
				tick_d = '0;
				wait_d = '0;
				sel_d = 1'b1;
				clk_d = 1'b1;
				dat_d = 1'b1;
			end
		end else if (running_q) begin
			tick_d = tick_inc;
			if (ent.kind == KIND_CMD) begin
				if (tick_q == '0) begin
					if (slot_q == 7'd0 || slot_q == last_slot) begin
						sel_d = 1'b1;
					end else if (slot_q == 7'd1) begin
						clk_d = 1'b1;
					end else if (slot_q == 7'd2) begin
						sel_d = 1'b0;
					end else begin
						case (sub_q)
							3'd0, 3'd4: clk_d = 1'b1;
							3'd1:       clk_d = 1'b0;
							3'd2:       dat_d = bit_val;
							default: ;
						endcase
					end
				end
				if (tick_inc >= pt) begin
					tick_d = '0;
					slot_d = slot_inc;
					if (slot_q >= 7'd3) begin
						if (sub_q == 3'd4) begin
							sub_d = '0;
							bit_d = bit_q + 5'd1;
						end else begin
							sub_d = sub_q + 3'd1;
						end
					end
					if (slot_inc > last_slot) begin
						do_adv = 1'b1;
					end
				end
			end else begin
				if (tick_inc >= pt) begin
					tick_d = '0;
					wait_d = wait_inc;
					if (wait_inc >= wlen) begin
						do_adv = 1'b1;
					end
				end
			end
			if (do_adv) begin
				step_d = step_adv;
				slot_d = '0;
				sub_d = '0;
				bit_d = '0;
				tick_d = '0;
				wait_d = '0;
				if (adv_end) begin
					running_d = 1'b0;
					step_d = '0;
					fin = 1'b1;
					status = (mode_q == MODE_UNKNOWN) ? STATUS_UNKNOWN : STATUS_OK;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			slot_q <= '0;
			sub_q <= '0;
			bit_q <= '0;
			tick_q <= '0;
			wait_q <= '0;
			mode_q <= MODE_ON;
			running_q <= 1'b0;
			sel_q <= 1'b1;
			clk_q <= 1'b1;
			dat_q <= 1'b1;
		end else if (take) begin
			step_q <= step_d;
			slot_q <= slot_d;
			sub_q <= sub_d;
			bit_q <= bit_d;
			tick_q <= tick_d;
			wait_q <= wait_d;
			mode_q <= mode_d;
			running_q <= running_d;
			sel_q <= sel_d;
			clk_q <= clk_d;
			dat_q <= dat_d;
		end
	end

	assign res = '{chip_select: sel_d, serial_clock: clk_d, serial_data: dat_d,
		busy_res: running_d, finished: fin, status: status};

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> (step_q == '0 && slot_q == '0 && tick_q == '0 && wait_q == '0))
		else $error("Idle sequencer holds a nonzero script position.");

	a_fin_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(take && res.finished) |=> !running_q)
		else $error("Script ended but the sequencer is still running.");

	a_sub_range: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q <= 3'd4 && bit_q <= 5'd18)
		else $error("Bit position counters left their range.");

	a_ignored_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(take && action && running_q) |=> ($stable(step_q) && $stable(slot_q) && running_q))
		else $error("Ignored start changed the script state.");

endmodule

### rtl/core/dispi9_outq.sv
module dispi9_outq import dispi9_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	output logic full,
	output logic head_valid,
	input  logic pop_ready,
	output res_t head_data
);

	res_t head_q;
	res_t skid_q;
	logic head_v_q;
	logic skid_v_q;
	logic pop;

	assign pop = head_v_q && pop_ready;
	assign full = skid_v_q;
	assign head_valid = head_v_q;
	assign head_data = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				head_v_q <= 1'b1;
				skid_v_q <= push;
			end else begin
				head_v_q <= push;
			end
		end else if (!head_v_q) begin
			head_v_q <= push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				head_q <= skid_q;
				if (push) begin
					skid_q <= push_data;
				end
			end else if (push) begin
				head_q <= push_data;
			end
		end else if (!head_v_q) begin
			if (push) begin
				head_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	a_skid_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> head_v_q)
		else $error("Skid entry is valid while the head is empty.");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_v_q)
		else $error("Transaction pushed into a full output queue.");

endmodule

### rtl/core/display_init_spi9_sequencer_top.sv
// Three-wire 9-bit SPI display init sequencer.
// Input transactions (in_valid/in_ready) carry action and mode. A start transaction
// picks the on, off, refresh or unknown script; each tick transaction advances the
// running script by one tick and updates the chip select, clock and data pin levels.
// Every input transaction yields exactly one result transaction (out_valid/out_ready)
// with the pin levels, busy_res, finished and status after that transaction.
// The result is registered in the output queue, valid once earlier results are taken.
// Throughput is one transaction per cycle while in_ready is high; the script state
// update is a single pass of logic between the state registers and the output queue.
// The output side is a two-entry queue, so an input is still taken while one result
// waits; when the receiver stalls and both entries are full, in_ready drops.
// Configuration writes (cfg_wen, cfg_index, cfg_wdata) take effect once registered and
// are meant to happen only while the block is idle.
// Reset clears the script state, sets the core's pin levels high, loads the register defaults
// and empties the output queue.
module display_init_spi9_sequencer_top import dispi9_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0]       cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       action,
	input  logic [1:0]                 mode,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       chip_select,
	output logic                       serial_clock,
	output logic                       serial_data,
	output logic                       busy_res,
	output logic                       finished,
	output logic [1:0]                 status
);

	logic full;
	logic take;
	res_t res;
	res_t head;

	assign in_ready = !full;
	assign take = in_valid && !full;

	dispi9_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.take(take),
		.action(action),
		.mode(mode),
		.res(res)
	);

	dispi9_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(take),
		.push_data(res),
		.full(full),
		.head_valid(out_valid),
		.pop_ready(out_ready),
		.head_data(head)
	);

	assign chip_select = head.chip_select;
	assign serial_clock = head.serial_clock;
	assign serial_data = head.serial_data;
	assign busy_res = head.busy_res;
	assign finished = head.finished;
	assign status = head.status;

endmodule
